// ===== src/qypr_pkg.sv =====
// Shared constants, types and functions for the quaternion to yaw, pitch and roll block.
`timescale 1ns / 1ps
package qypr_pkg;

	// CORDIC datapath and angle widths
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DW                = 50;
	localparam int ZW                = 33;
	localparam int ANG_TAB_LEN       = 24;

	localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314857;
	localparam logic signed [31:0]   GAIN_Q30    = 32'sd1768195363;
	localparam logic signed [15:0]   YAW_LIM     = 16'sd25736;
	localparam logic signed [15:0]   PITCH_LIM   = 16'sd12868;

	typedef logic signed [DW-1:0] data_t;
	typedef logic signed [ZW-1:0] ang_t;

	// one word travelling along a CORDIC chain
	typedef struct packed {
		logic  vld;
		logic  zero;
		data_t x;
		data_t y;
		ang_t  z;
	} cord_t;

	// atan(2^-i) rounded to Q.29
	function automatic ang_t atan_q29(input int idx);
		ang_t r;
		r = '0;
		unique case (idx)
			0:  r = 33'sd421657428;
			1:  r = 33'sd248918915;
			2:  r = 33'sd131521918;
			3:  r = 33'sd66762579;
			4:  r = 33'sd33510843;
			5:  r = 33'sd16771758;
			6:  r = 33'sd8387925;
			7:  r = 33'sd4194219;
			8:  r = 33'sd2097141;
			9:  r = 33'sd1048575;
			10: r = 33'sd524288;
			11: r = 33'sd262144;
			12: r = 33'sd131072;
			13: r = 33'sd65536;
			14: r = 33'sd32768;
			15: r = 33'sd16384;
			16: r = 33'sd8192;
			17: r = 33'sd4096;
			18: r = 33'sd2048;
			19: r = 33'sd1024;
			20: r = 33'sd512;
			21: r = 33'sd256;
			22: r = 33'sd128;
			23: r = 33'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q.29 to Q3.13, round half up, clamp to +-lim, zero vector gives 0
	function automatic logic signed [15:0] round_q13(input ang_t z, input logic zero,
			input logic signed [15:0] lim);
		logic signed [ZW:0]    s;
		logic signed [ZW-16:0] r;
		logic signed [ZW-16:0] l;
		logic signed [15:0]    o;
		s = {z[ZW-1], z} + (ZW+1)'(32768);
		r = s[ZW:16];
		l = (ZW-15)'(lim);
		if (zero)
			o = '0;
		else if (r > l)
			o = lim;
		else if (r < -l)
			o = -lim;
		else
			o = r[15:0];
		return o;
	endfunction

endpackage

// ===== src/quaternion_to_yaw_pitch_roll.sv =====
// Top level: quaternion and gravity vector to yaw, pitch and roll angles.
`timescale 1ns / 1ps
// Fully pipelined: a word is taken on every cycle that start is high (busy is
// always low) and its angles appear on yaw_angle, pitch_angle and roll_angle
// with done high for one cycle, after stage 1, two CORDIC chains in series
// and the output register. Yaw and roll run side by side, and pitch needs
// the gravity magnitude left by the roll chain, so its chain comes after. Results
// cannot be held off, so the receiver must take each word in its done cycle.
module quaternion_to_yaw_pitch_roll
	import qypr_pkg::*;
#(
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] grav_x,
	input  logic signed [15:0] grav_y,
	input  logic signed [15:0] grav_z,
	output logic               done,
	output logic signed [15:0] yaw_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] roll_angle
);

	localparam int LAT = 2 * CORDIC_STAGES + 4;

	logic               vld_s1;
	logic signed [31:0] pxy_s1, pwz_s1, pww_s1, pxx_s1;
	logic signed [47:0] gxk_s1;
	logic signed [15:0] gy_s1, gz_s1;

	data_t yaw_x, yaw_y, roll_x, roll_y, pit_x;
	cord_t yaw_c  [CORDIC_STAGES+1];
	cord_t roll_c [CORDIC_STAGES+1];
	cord_t pit_c  [CORDIC_STAGES+1];

	logic signed [47:0] gxk_q [CORDIC_STAGES+1];
	logic signed [15:0] yaw_q  [CORDIC_STAGES+1];
	logic signed [15:0] roll_q [CORDIC_STAGES+1];
	logic signed [15:0] pit_r;

	assign busy = 1'b0;

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		pxy_s1 <= 32'(quat_x) * 32'(quat_y);
		pwz_s1 <= 32'(quat_w) * 32'(quat_z);
		pww_s1 <= 32'(quat_w) * 32'(quat_w);
		pxx_s1 <= 32'(quat_x) * 32'(quat_x);
		gxk_s1 <= 48'(grav_x) * 48'(GAIN_Q30);
		gy_s1  <= grav_y;
		gz_s1  <= grav_z;
	end

	// operands in the widened datapath
	assign yaw_y  = (DW'(pxy_s1) - DW'(pwz_s1)) <<< 1;
	assign yaw_x  = ((DW'(pww_s1) + DW'(pxx_s1)) <<< 1) - (DW'(1) <<< 28);
	assign roll_y = DW'(gy_s1) <<< 20;
	assign roll_x = DW'(gz_s1) <<< 20;

	qypr_cordic_pre u_yaw_pre (
		.clk(clk), .arst_n(arst_n), .vld(vld_s1), .x(yaw_x), .y(yaw_y), .q(yaw_c[0])
	);
	qypr_cordic_pre u_roll_pre (
		.clk(clk), .arst_n(arst_n), .vld(vld_s1), .x(roll_x), .y(roll_y), .q(roll_c[0])
	);

	// yaw and roll chains side by side
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_yr
		qypr_cordic_cell #(.IDX(i)) u_yaw (
			.clk(clk), .arst_n(arst_n), .d(yaw_c[i]), .q(yaw_c[i+1])
		);
		qypr_cordic_cell #(.IDX(i)) u_roll (
			.clk(clk), .arst_n(arst_n), .d(roll_c[i]), .q(roll_c[i+1])
		);
	end

	// gx times gain waits for the roll magnitude
	always_ff @(posedge clk) begin
		gxk_q[0] <= gxk_s1;
		for (int i = 1; i <= CORDIC_STAGES; i++)
			gxk_q[i] <= gxk_q[i-1];
	end

	assign pit_x = roll_c[CORDIC_STAGES].x <<< 10;

	qypr_cordic_pre u_pit_pre (
		.clk(clk), .arst_n(arst_n), .vld(roll_c[CORDIC_STAGES].vld), .x(pit_x),
		.y(DW'(gxk_q[CORDIC_STAGES])), .q(pit_c[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_p
		qypr_cordic_cell #(.IDX(i)) u_pit (
			.clk(clk), .arst_n(arst_n), .d(pit_c[i]), .q(pit_c[i+1])
		);
	end

	// rounded yaw and roll wait for pitch: pre stage plus the chain
	always_ff @(posedge clk) begin
		yaw_q[0]  <= round_q13(yaw_c[CORDIC_STAGES].z, yaw_c[CORDIC_STAGES].zero, YAW_LIM);
		roll_q[0] <= round_q13(roll_c[CORDIC_STAGES].z, roll_c[CORDIC_STAGES].zero, YAW_LIM);
		for (int i = 1; i <= CORDIC_STAGES; i++) begin
			yaw_q[i]  <= yaw_q[i-1];
			roll_q[i] <= roll_q[i-1];
		end
	end

	assign pit_r = round_q13(pit_c[CORDIC_STAGES].z, pit_c[CORDIC_STAGES].zero, PITCH_LIM);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= pit_c[CORDIC_STAGES].vld;
		end
	end

	always_ff @(posedge clk) begin
		yaw_angle   <= yaw_q[CORDIC_STAGES];
		roll_angle  <= roll_q[CORDIC_STAGES];
		pitch_angle <= pit_r[14:0];
	end

	// checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("word lost in pipeline");
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("result without a word");
	a_pitch_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868))
		else $error("pitch out of range");

endmodule

// ===== src/qypr_cordic_pre.sv =====
// Quadrant fold and zero detect ahead of a CORDIC chain.
`timescale 1ns / 1ps
module qypr_cordic_pre
	import qypr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld,
	input  data_t x,
	input  data_t y,
	output cord_t q
);

	cord_t d;
	logic  vld_q;
	logic  zero_q;
	data_t x_q;
	data_t y_q;
	ang_t  z_q;

	// turn left half plane vectors by +-pi/2
	always_comb begin
		d.vld  = vld;
		d.zero = (x == '0) && (y == '0);
		d.x    = x;
		d.y    = y;
		d.z    = '0;
		if (x < 0) begin
			if (y >= 0) begin
				d.x = y;
				d.y = -x;
				d.z = HALF_PI_Q29;
			end else begin
				d.x = -y;
				d.y = x;
				d.z = -HALF_PI_Q29;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		zero_q <= d.zero;
		x_q    <= d.x;
		y_q    <= d.y;
		z_q    <= d.z;
	end

	assign q = '{vld: vld_q, zero: zero_q, x: x_q, y: y_q, z: z_q};

endmodule

// ===== src/qypr_cordic_cell.sv =====
// One vectoring-mode CORDIC micro-rotation with its output register.
`timescale 1ns / 1ps
module qypr_cordic_cell
	import qypr_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cord_t d,
	output cord_t q
);

	data_t dx;
	data_t dy;
	cord_t n;
	logic  vld_q;
	logic  zero_q;
	data_t x_q;
	data_t y_q;
	ang_t  z_q;

	// rotate toward the x axis
	always_comb begin
		dx     = d.y >>> IDX;
		dy     = d.x >>> IDX;
		n.vld  = d.vld;
		n.zero = d.zero;
		if (d.y > 0) begin
			n.x = d.x + dx;
			n.y = d.y - dy;
			n.z = d.z + atan_q29(IDX);
		end else begin
			n.x = d.x - dx;
			n.y = d.y + dy;
			n.z = d.z - atan_q29(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= n.vld;
		end
	end

	always_ff @(posedge clk) begin
		zero_q <= n.zero;
		x_q    <= n.x;
		y_q    <= n.y;
		z_q    <= n.z;
	end

	assign q = '{vld: vld_q, zero: zero_q, x: x_q, y: y_q, z: z_q};

endmodule

// ===== tb/sv/tb_quaternion_to_yaw_pitch_roll.sv =====
// Testbench for the quaternion and gravity to yaw, pitch and roll block.
`timescale 1ns / 1ps
module tb_quaternion_to_yaw_pitch_roll;
	import qypr_pkg::*;

	localparam int STAGES  = DEF_CORDIC_STAGES;
	localparam int LATENCY = 2 * STAGES + 4;

	// one input word and one angle word
	typedef struct {
		logic signed [15:0] qw, qx, qy, qz, gx, gy, gz;
	} att_word_t;
	typedef struct {
		logic signed [15:0] yaw;
		logic signed [14:0] pitch;
		logic signed [15:0] roll;
	} angle_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic signed [15:0] grav_x = '0, grav_y = '0, grav_z = '0;
	logic signed [15:0] yaw_angle, roll_angle;
	logic signed [14:0] pitch_angle;

	angle_word_t angles_due[$];
	int mismatches = 0;
	bit no_gaps = 1'b0;

	quaternion_to_yaw_pitch_roll #(.CORDIC_STAGES(STAGES)) dut (.*);

	always #10 clk = ~clk;

	// floor division by 2^s
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	// vectoring CORDIC; returns angle in Q.29, mag gets gain times length
	function automatic longint vec_angle(longint y, longint x, output longint mag);
		longint z, t, dx, dy;
		longint tab[24] = '{421657428, 248918915, 131521918, 66762579, 33510843,
			16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072,
			65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
		z = 0;
		mag = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 843314857;
			end else begin
				x = -y; y = t; z = -843314857;
			end
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += tab[i];
			end else begin
				x -= dx; y += dy; z -= tab[i];
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic longint angle_q13(longint z, longint lim);
		longint r;
		r = shr_floor(z + 32768, 16);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic angle_word_t predict_angles(att_word_t a);
		angle_word_t o;
		longint yy, yx, mag, dummy;
		yy = 2 * longint'(a.qx) * a.qy - 2 * longint'(a.qw) * a.qz;
		yx = 2 * longint'(a.qw) * a.qw + 2 * longint'(a.qx) * a.qx - (longint'(1) << 28);
		o.yaw = 16'(angle_q13(vec_angle(yy, yx, dummy), 25736));
		o.roll = 16'(angle_q13(vec_angle(longint'(a.gy) <<< 20, longint'(a.gz) <<< 20, mag),
			25736));
		o.pitch = 15'(angle_q13(vec_angle(longint'(a.gx) * 1768195363, mag * 1024, dummy),
			12868));
		return o;
	endfunction

	// send one word, random idle before it
	task automatic send_word(att_word_t a);
		while (!no_gaps && $urandom_range(99) < 11) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		{quat_w, quat_x, quat_y, quat_z} <= {a.qw, a.qx, a.qy, a.qz};
		{grav_x, grav_y, grav_z} <= {a.gx, a.gy, a.gz};
		@(posedge clk);
		while (busy) @(posedge clk);
		angles_due.push_back(predict_angles(a));
		@(negedge clk);
	endtask

	task automatic send_vals(int qw, int qx, int qy, int qz, int gx, int gy, int gz);
		att_word_t a;
		a = '{16'(qw), 16'(qx), 16'(qy), 16'(qz), 16'(gx), 16'(gy), 16'(gz)};
		send_word(a);
	endtask

	function automatic logic signed [15:0] rnd_unit();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// extremes, zero vectors, left half plane, full 16-bit patterns
	task automatic test_directed();
		send_vals(16384, 0, 0, 0, 0, 0, 16384);
		send_vals(0, 0, 0, 0, 0, 0, 0);
		send_vals(11585, 11585, 0, 0, 16384, 0, 0);
		send_vals(-16384, 0, 0, 0, -16384, 0, 0);
		send_vals(0, 16384, 16384, 0, 0, 16384, -16384);
		send_vals(0, 0, 0, 16384, 0, -16384, -16384);
		send_vals(8192, -8192, 8192, 8192, 0, 0, -16384);
		send_vals(0, 0, 0, 0, 0, 0, -1);
		send_vals(0, 0, 1, 1, 1, 0, 0);
		send_vals(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_vals(32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_vals(32767, -32768, 32767, -32768, 32767, -32768, 32767);
		send_vals(0, 0, 0, 0, 16384, 0, 0);
		send_vals(0, 0, 0, 0, -16384, 0, 0);
		send_vals(11585, 0, 0, -11585, 5000, -1, -16000);
		send_vals(11585, 0, 0, 11585, -5000, 1, -16000);
		send_vals(-1, -1, -1, -1, -1, -1, -1);
	endtask

	// random words: mostly unit-range, some any 16-bit pattern
	task automatic test_random(int n, bit back_to_back);
		att_word_t a;
		no_gaps = back_to_back;
		repeat (n) begin
			if ($urandom_range(9) < 8)
				a = '{rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit(),
					rnd_unit(), rnd_unit(), rnd_unit()};
			else
				a = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom)};
			send_word(a);
		end
		no_gaps = 1'b0;
	endtask

	// compare each done word with the oldest prediction
	always @(posedge clk) begin
		angle_word_t e;
		if (arst_n && done) begin
			if (angles_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word at %0t", $realtime);
			end else begin
				e = angles_due.pop_front();
				if (e.yaw !== yaw_angle || e.pitch !== pitch_angle || e.roll !== roll_angle)
					begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
							e.yaw, e.pitch, e.roll, yaw_angle, pitch_angle, roll_angle);
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(200, 1'b0);
		test_random(60, 1'b1);
		test_random(190, 1'b0);
		start <= 1'b0;
		while (angles_due.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
